>>> rtl/core/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
// No dependencies; imported by every module of the block.
package sfs_pkg;

    localparam int SPRITE_W       = 16;
    localparam int LEN_W          = 16;
    localparam int TIME_W         = 22;
    localparam int STEP_W         = 32;  // elapsed times speed
    localparam int SUM_W          = 25;  // play time plus scaled step
    localparam int POS_W          = 6;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;
    localparam int MAX_FRAMES_DEF = 64;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    localparam logic [1:0] FUNC_APPEND  = 2'd0;
    localparam logic [1:0] FUNC_INSERT  = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;
    localparam logic [1:0] FUNC_RESTART = 2'd3;

    localparam logic [1:0] WRAP_CLAMP    = 2'd0;
    localparam logic [1:0] WRAP_LOOP     = 2'd1;
    localparam logic [1:0] WRAP_PINGPONG = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_REV  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_SPEED = 2'd2;

    localparam logic [15:0] SPEED_ONE = 16'd256;

    typedef struct packed {
        logic [SPRITE_W-1:0] sprite;
        logic [LEN_W-1:0]    length;
    } t_frame;

endpackage

>>> rtl/core/sfs_frame_mem.sv
// Frame table: one synchronous memory of sprite/duration pairs.
// One write port, one read port with registered data. Uses sfs_pkg.
module sfs_frame_mem #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_waddr,
    input  sfs_pkg::t_frame               i_wdata,
    input  logic [$clog2(MAX_FRAMES)-1:0] i_raddr,
    output sfs_pkg::t_frame               o_rdata
);
    import sfs_pkg::*;

    t_frame r_mem [MAX_FRAMES];
    t_frame r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sfs_divider.sv
// Bit-serial remainder unit: one quotient bit per cycle.
// Uses sfs_pkg for widths.
module sfs_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sfs_pkg::SUM_W-1:0] i_dividend,
    input  logic [sfs_pkg::TIME_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [sfs_pkg::TIME_W-1:0] o_rem
);
    import sfs_pkg::*;

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [TIME_W-1:0] r_rem;
    logic [SUM_W-1:0]  r_q;
    logic [TIME_W-1:0] r_div;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [TIME_W:0]   shifted;
    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] n_rem;

    always_comb begin
        shifted = {r_rem, r_q[SUM_W-1]};
        diff    = shifted - {1'b0, r_div};
        n_rem   = (shifted >= {1'b0, r_div}) ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_q    <= i_dividend;
                r_div  <= i_divisor;
                r_cnt  <= CNT_W'(SUM_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_q   <= {r_q[SUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> rtl/core/sprite_frame_sequencer.sv
// Sprite frame sequencer: a table of frames (sprite id, duration) in one
// synchronous memory, a running total and a play time with clamp, loop or
// ping-pong wrap. One item at a time; each gives one result word. Append and
// restart go straight to the lookup; insert first shifts the frames from the
// position up (each step reads one entry and writes the one read before) and
// then writes the new frame; advance multiplies, adds and wraps and, in loop or
// ping-pong mode, runs the bit-serial remainder. The lookup walks the table
// at one frame per cycle through the read port.
// A new word is taken while the previous result still waits on the output.
module sprite_frame_sequencer #(
    parameter int MAX_FRAMES = sfs_pkg::MAX_FRAMES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // frame_present[0], sprite_id[16:1], frame_duration[32:17],
    // position[38:33], elapsed[54:39], zero fill
    input  logic [55:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // accepted[0], frame_valid[1], shown_sprite[17:2],
    // play_time_out[39:18], reversed_out[40], zero fill
    output logic [47:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [sfs_pkg::CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [sfs_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import sfs_pkg::*;

    localparam int AW = $clog2(MAX_FRAMES);
    localparam int CW = AW + 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam int SW = (LEN_W + CW > TIME_W) ? LEN_W + CW : TIME_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SHIFT, ST_SHIFT_END, ST_INS_WR, ST_MUL, ST_ADD, ST_WRAP,
        ST_DIV, ST_LOOK_INIT, ST_LOOK, ST_LAST, ST_DONE
    } t_state;

    t_state r_state;

    logic [1:0]  r_wrap;
    logic        r_start_rev;
    logic [15:0] r_speed;

    logic [SPRITE_W-1:0] r_sprite_in;
    logic [LEN_W-1:0]    r_dur_in;
    logic [POS_W-1:0]    r_pos;
    logic [15:0]         r_elapsed;

    logic [CW-1:0]     r_count;
    logic [TIME_W-1:0] r_total;
    logic [TIME_W-1:0] r_pt;
    logic              r_rev;
    logic              r_acc;

    logic [CW-1:0]     r_i;
    logic [AW-1:0]     r_wa;
    logic              r_wv;
    logic [SW-1:0]     r_start;
    logic              r_cv;
    logic [STEP_W-1:0] r_prod;
    logic [SUM_W-1:0]  r_t;
    logic [SPRITE_W-1:0] r_shown;

    logic        r_ov;
    logic [47:0] r_odata;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    t_frame        mem_wd;
    logic [AW-1:0] mem_ra;
    t_frame        mem_rd;

    logic              div_start;
    logic              div_done;
    logic [TIME_W-1:0] div_rem;

    logic [TIME_W:0]   total_sum;
    logic [TIME_W-1:0] total_sat;
    logic [CW-1:0]     look_idx;
    logic [CW-1:0]     last_idx;
    logic [SW-1:0]     look_end;
    logic              look_hit;
    logic              ins_ok;
    logic              in_fire;
    logic              wrap_div;

    sfs_frame_mem #(.MAX_FRAMES(MAX_FRAMES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_wa),
        .i_wdata (mem_wd),
        .i_raddr (mem_ra),
        .o_rdata (mem_rd)
    );

    sfs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_t),
        .i_divisor  (r_total),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_odata;

    assign total_sum = {1'b0, r_total} + {{(TIME_W + 1 - LEN_W){1'b0}}, r_dur_in};
    assign total_sat = total_sum[TIME_W] ? TIME_MAX : total_sum[TIME_W-1:0];
    assign last_idx  = r_count - 1'b1;
    assign look_idx  = r_rev ? (last_idx - r_i) : r_i;
    assign look_end  = r_start + {{(SW - LEN_W){1'b0}}, mem_rd.length};
    assign look_hit  = r_cv && ({{(SW - TIME_W){1'b0}}, r_pt} < look_end);
    assign ins_ok    = s_axis_tdata[0]
                     && ({{(PW - POS_W){1'b0}}, s_axis_tdata[38:33]}
                         < {{(PW - CW){1'b0}}, r_count})
                     && (r_count < CW'(MAX_FRAMES));
    assign wrap_div  = (r_wrap == WRAP_LOOP || r_wrap == WRAP_PINGPONG)
                     && (r_total != '0);
    assign div_start = (r_state == ST_WRAP) && wrap_div;

    // memory port steering
    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_wa;
        mem_wd = mem_rd;
        mem_ra = last_idx[AW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                mem_we = in_fire && (s_axis_tuser == FUNC_APPEND) && s_axis_tdata[0]
                       && (r_count < CW'(MAX_FRAMES));
                mem_wa = r_count[AW-1:0];
                mem_wd = '{sprite: s_axis_tdata[16:1], length: s_axis_tdata[32:17]};
            end
            ST_SHIFT: begin
                mem_we = r_wv;
                mem_ra = last_idx[AW-1:0] - last_idx[AW-1:0] + (r_i[AW-1:0] - 1'b1);
            end
            ST_SHIFT_END: begin
                mem_we = r_wv;
            end
            ST_INS_WR: begin
                mem_we = 1'b1;
                mem_wa = AW'(r_pos);
                mem_wd = '{sprite: r_sprite_in, length: r_dur_in};
            end
            ST_LOOK: begin
                mem_ra = (r_i < r_count) ? look_idx[AW-1:0] : last_idx[AW-1:0];
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wrap      <= WRAP_CLAMP;
            r_start_rev <= 1'b0;
            r_speed     <= SPEED_ONE;
            r_count     <= '0;
            r_total     <= '0;
            r_pt        <= '0;
            r_rev       <= 1'b0;
            r_wv        <= 1'b0;
            r_cv        <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_WRAP_MODE:  r_wrap      <= i_cfg_wdata[1:0];
                    CFG_START_REV:  r_start_rev <= i_cfg_wdata[0];
                    CFG_PLAY_SPEED: r_speed     <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (r_ov && m_axis_tready && r_state != ST_DONE) begin
                r_ov <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_sprite_in <= s_axis_tdata[16:1];
                        r_dur_in    <= s_axis_tdata[32:17];
                        r_pos       <= s_axis_tdata[38:33];
                        r_elapsed   <= s_axis_tdata[54:39];
                        r_acc       <= 1'b0;
                        r_wv        <= 1'b0;
                        unique case (s_axis_tuser)
                            FUNC_APPEND: begin
                                if (mem_we) begin
                                    r_count <= r_count + 1'b1;
                                    r_total <= (({1'b0, r_total}
                                        + {{(TIME_W + 1 - LEN_W){1'b0}},
                                           s_axis_tdata[32:17]}) > {1'b0, TIME_MAX})
                                        ? TIME_MAX
                                        : r_total + {{(TIME_W - LEN_W){1'b0}},
                                                     s_axis_tdata[32:17]};
                                    r_acc   <= 1'b1;
                                end
                                r_state <= ST_LOOK_INIT;
                            end
                            FUNC_INSERT: begin
                                r_i     <= r_count;
                                r_state <= ins_ok ? ST_SHIFT : ST_LOOK_INIT;
                            end
                            FUNC_ADVANCE: begin
                                r_state <= ST_MUL;
                            end
                            default: begin
                                r_pt    <= '0;
                                r_rev   <= r_start_rev;
                                r_state <= ST_LOOK_INIT;
                            end
                        endcase
                    end
                end
                ST_SHIFT: begin
                    // read entry i-1 now, write it to i next cycle
                    r_wv <= 1'b1;
                    r_wa <= r_i[AW-1:0];
                    r_i  <= r_i - 1'b1;
                    if (r_i - 1'b1 == CW'(r_pos)) begin
                        r_state <= ST_SHIFT_END;
                    end
                end
                ST_SHIFT_END: begin
                    r_wv    <= 1'b0;
                    r_state <= ST_INS_WR;
                end
                ST_INS_WR: begin
                    r_count <= r_count + 1'b1;
                    r_total <= total_sat;
                    r_acc   <= 1'b1;
                    r_state <= ST_LOOK_INIT;
                end
                ST_MUL: begin
                    r_prod  <= r_elapsed * r_speed;
                    r_state <= ST_ADD;
                end
                ST_ADD: begin
                    r_t <= {{(SUM_W - TIME_W){1'b0}}, r_pt}
                         + {1'b0, r_prod[STEP_W-1:8]};
                    r_state <= ST_WRAP;
                end
                ST_WRAP: begin
                    r_state <= wrap_div ? ST_DIV : ST_LOOK_INIT;
                    case (r_wrap) inside
                        WRAP_CLAMP: begin
                            r_pt <= (r_t >= {{(SUM_W - TIME_W){1'b0}}, r_total})
                                  ? r_total : r_t[TIME_W-1:0];
                        end
                        WRAP_LOOP, WRAP_PINGPONG: begin
                            if (!wrap_div) begin
                                r_pt <= '0;
                            end else if (r_wrap == WRAP_PINGPONG
                                && r_t >= {{(SUM_W - TIME_W){1'b0}}, r_total}) begin
                                r_rev <= !r_rev;
                            end
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (div_done) begin
                        r_pt    <= div_rem;
                        r_state <= ST_LOOK_INIT;
                    end
                end
                ST_LOOK_INIT: begin
                    r_i     <= '0;
                    r_start <= '0;
                    r_cv    <= 1'b0;
                    r_shown <= '0;
                    r_state <= (r_count == '0) ? ST_DONE : ST_LOOK;
                end
                ST_LOOK: begin
                    if (look_hit) begin
                        r_shown <= mem_rd.sprite;
                        r_cv    <= 1'b0;
                        r_state <= ST_DONE;
                    end else begin
                        if (r_cv) begin
                            r_start <= look_end;
                        end
                        if (r_i < r_count) begin
                            r_i  <= r_i + 1'b1;
                            r_cv <= 1'b1;
                        end else begin
                            // no frame covers the time: fetch the last one
                            r_cv    <= 1'b0;
                            r_state <= ST_LAST;
                        end
                    end
                end
                ST_LAST: begin
                    r_shown <= mem_rd.sprite;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (!r_ov || m_axis_tready) begin
                        r_ov    <= 1'b1;
                        r_odata <= {7'd0, r_rev, r_pt, r_shown,
                                    (r_count != '0), r_acc};
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule
